>>> hw/rtl/bdrs_pkg.sv
package bdrs_pkg;

  typedef enum logic [1:0] {
    CMD_WR_DIST  = 2'd0,
    CMD_WR_CYCLE = 2'd1,
    CMD_WR_REF   = 2'd2,
    CMD_COMPUTE  = 2'd3
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_CYCLE_LEN = 1'd0,
    CFG_REF_LEN   = 1'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CAND,
    ST_RD,
    ST_ACC,
    ST_CMP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_PUSH
  } state_e;

  localparam int unsigned CmdW    = 2;
  localparam int unsigned NodeW   = 5;
  localparam int unsigned InDistW = 16;
  localparam int unsigned SumW    = 25;
  localparam int unsigned ScoreW  = 26;
  localparam int unsigned MisW    = 6;
  localparam int unsigned RouteCap = 32;

  typedef struct packed {
    logic [CmdW-1:0]    command;
    logic [NodeW-1:0]   from_node;
    logic [NodeW-1:0]   to_node;
    logic [InDistW-1:0] distance;
  } item_t;

  typedef struct packed {
    logic [NodeW-1:0] position;
    logic [NodeW-1:0] route_node;
    logic [SumW-1:0]  arrival_sum;
    logic [MisW-1:0]  mismatch_count;
    logic             last;
  } result_t;

endpackage

>>> hw/rtl/best_depot_rotation_search.sv
// Best depot rotation search.
// Input channel (push/full): each beat is one command. Distance, cycle
// and reference writes are taken into on-chip stores; a compute beat scores
// every rotation of the loaded cycle, forward then reversed, behind depot 0.
// Beats enter a two-entry queue in front of the engine, so the sender is
// held off only when that queue fills.
// Result channel (empty/pop): a compute produces cycle_length+1 beats,
// one per route node, through a two-entry result queue; when the receiver
// stalls the engine holds its current beat and waits.
// Configuration: cfg_valid/cfg_ready write cycle_length (index 0) or
// reference_length (index 1); write only while idle.
// Sequence: the engine takes a load beat while idle. A compute first starts,
// then scores each of its 2*N candidates with a setup step, a read and an
// accumulate step per node (the distance read is registered) and a compare;
// each route that improves on the best so far is copied node by node, and
// each result beat is read, waited on and pushed, held while the receiver
// stalls. An empty cycle passes the setup state, then emits its single beat.
// Reset empties the queues, clears the lengths and the engine state and sets
// the best score to all ones; the stores hold undefined data until written.
module best_depot_rotation_search #(
  parameter int unsigned MAX_NODES = 32,
  parameter int unsigned DIST_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [4:0]  from_node_i,
  input  logic [4:0]  to_node_i,
  input  logic [15:0] distance_i,
  output logic        empty,
  input  logic        pop,
  output logic [4:0]  position_o,
  output logic [4:0]  route_node_o,
  output logic [24:0] arrival_sum_o,
  output logic [5:0]  mismatch_count_o,
  output logic        last_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bdrs_pkg::*;

  item_t   in_item, q_item;
  result_t res, out_res;
  logic    q_empty, eng_ready, res_push, res_full;
  logic [4:0] cyc_len_q;
  logic [5:0] ref_len_q;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc_len_q <= '0;
      ref_len_q <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_CYCLE_LEN: cyc_len_q <= cfg_data[4:0];
        CFG_REF_LEN:   ref_len_q <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign in_item = '{command: command_i, from_node: from_node_i,
                     to_node: to_node_i, distance: distance_i};

  bdrs_fifo #(.Width($bits(item_t)), .Depth(2)) u_in_q (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item), .full_o(full),
    .pop_i(eng_ready), .data_o(q_item), .empty_o(q_empty)
  );

  bdrs_engine #(.MaxNodes(MAX_NODES), .DistBits(DIST_BITS)) u_engine (
    .clk_i, .rst_ni,
    .cycle_length_i(cyc_len_q), .reference_length_i(ref_len_q),
    .item_valid_i(!q_empty), .item_i(q_item), .item_ready_o(eng_ready),
    .res_push_o(res_push), .res_o(res), .res_full_i(res_full)
  );

  bdrs_fifo #(.Width($bits(result_t)), .Depth(2)) u_out_q (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(out_res), .empty_o(empty)
  );

  assign position_o       = out_res.position;
  assign route_node_o     = out_res.route_node;
  assign arrival_sum_o    = out_res.arrival_sum;
  assign mismatch_count_o = out_res.mismatch_count;
  assign last_o           = out_res.last;
endmodule

>>> hw/rtl/bdrs_fifo.sv
module bdrs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_q, rd_q;
  logic [AW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

>>> hw/rtl/bdrs_engine.sv
module bdrs_engine #(
  parameter int unsigned MaxNodes = 32,
  parameter int unsigned DistBits = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [4:0]           cycle_length_i,
  input  logic [5:0]           reference_length_i,
  input  logic                 item_valid_i,
  input  bdrs_pkg::item_t      item_i,
  output logic                 item_ready_o,
  output logic                 res_push_o,
  output bdrs_pkg::result_t    res_o,
  input  logic                 res_full_i
);
  import bdrs_pkg::*;

  localparam int unsigned IW  = (MaxNodes > 1) ? $clog2(MaxNodes) : 1;
  localparam int unsigned MemD = MaxNodes * MaxNodes;
  localparam int unsigned MemAW = (MemD > 1) ? $clog2(MemD) : 1;
  // A route of at most 31 hops sums at most 496 travel times.
  localparam int unsigned ScW = DistBits + 9;

  // Stores.
  logic [DistBits-1:0] dist_mem [MemD];
  logic [NodeW-1:0]    cyc_mem  [MaxNodes];
  logic [NodeW-1:0]    ref_mem  [MaxNodes];
  logic [NodeW-1:0]    cand_mem [RouteCap];
  logic [NodeW-1:0]    best_mem [RouteCap];

  state_e state_q, state_d;
  logic [4:0]  n_q;
  logic [5:0]  r_q;
  logic        dir_q;
  logic [4:0]  cut_q, k_q, p_q;
  logic [NodeW-1:0] prev_q, cur_q;
  logic        oob_q;
  logic [DistBits-1:0] drd_q;
  logic [NodeW-1:0]    refrd_q;
  logic [ScW-1:0]      arr_q, tot_q, best_s_q;
  logic [MisW-1:0]     mis_q, best_m_q;
  logic        have_q;
  logic [NodeW-1:0]    crd_q;

  logic [5:0] len;
  logic [4:0] p_next;
  assign len = {1'b0, n_q} + 6'd1;

  always_comb begin
    p_next = (p_q == n_q - 5'd1) ? 5'd0 : p_q + 5'd1;
  end

  logic [4:0] pidx;
  assign pidx = dir_q ? (n_q - 5'd1 - p_q) : p_q;

  // Load writes.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      unique case (cmd_e'(item_i.command))
        CMD_WR_DIST: begin
          if (32'(item_i.from_node) < MaxNodes && 32'(item_i.to_node) < MaxNodes) begin
            dist_mem[MemAW'(item_i.from_node) * MemAW'(MaxNodes) +
                     MemAW'(item_i.to_node)] <= DistBits'(item_i.distance);
          end
        end
        CMD_WR_CYCLE: begin
          if (32'(item_i.from_node) < MaxNodes) begin
            cyc_mem[IW'(item_i.from_node)] <= item_i.to_node;
          end
        end
        CMD_WR_REF: begin
          if (32'(item_i.from_node) < MaxNodes) begin
            ref_mem[IW'(item_i.from_node)] <= item_i.to_node;
          end
        end
        default: ;
      endcase
    end
  end

  // Distance, reference and candidate reads, all registered.
  logic [NodeW-1:0] cyc_node;
  logic [5:0] pos_c;
  assign cyc_node = cyc_mem[IW'(pidx)];
  assign pos_c = {1'b0, k_q} + 6'd1;
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) begin
      drd_q   <= dist_mem[MemAW'(prev_q) * MemAW'(MaxNodes) + MemAW'(cyc_node)];
      oob_q   <= (32'(prev_q) >= MaxNodes) || (32'(cyc_node) >= MaxNodes);
      cur_q   <= cyc_node;
      refrd_q <= ref_mem[IW'(pos_c)];
      cand_mem[pos_c[4:0]] <= cyc_node;
    end
    if (state_q == ST_COPY_RD) begin
      crd_q <= cand_mem[k_q];
    end
    if (state_q == ST_COPY_WR) begin
      best_mem[k_q] <= crd_q;
    end
    if (state_q == ST_EMIT_RD) begin
      crd_q <= (k_q == 5'd0) ? '0 : best_mem[k_q];
    end
    if (state_q == ST_CAND) begin
      refrd_q <= ref_mem[0];
    end
  end

  logic [ScW-1:0] arr_n, tot_n;
  logic [MisW-1:0] mis_fin;
  logic [5:0] big, lim;
  always_comb begin
    arr_n = arr_q + (oob_q ? '0 : ScW'(drd_q));
    tot_n = tot_q + arr_n;
    lim = (r_q < len) ? r_q : len;
    big = (r_q < len) ? len : r_q;
    mis_fin = mis_q + (big - lim);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      best_s_q <= '1;
      best_m_q <= '1;
      have_q   <= 1'b0;
      n_q <= '0; r_q <= '0; dir_q <= 1'b0; cut_q <= '0; k_q <= '0; p_q <= '0;
      prev_q <= '0; arr_q <= '0; tot_q <= '0; mis_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (item_valid_i && cmd_e'(item_i.command) == CMD_COMPUTE) begin
            n_q <= (32'(cycle_length_i) > MaxNodes - 1) ? 5'(MaxNodes - 1) : cycle_length_i;
            r_q <= (32'(reference_length_i) > MaxNodes) ? 6'(MaxNodes)
                 : ((reference_length_i > 6'd32) ? 6'd32 : reference_length_i);
            dir_q <= 1'b0; cut_q <= '0; have_q <= 1'b0;
          end
        end
        ST_CAND: begin
          k_q <= '0; p_q <= cut_q; prev_q <= '0; arr_q <= '0; tot_q <= '0;
          mis_q <= '0;
        end
        ST_RD: begin
          // The depot position is compared once, on the first node step.
          if (k_q == 5'd0 && r_q != 6'd0 && refrd_q != 5'd0) mis_q <= mis_q + 1'b1;
        end
        ST_ACC: begin
          arr_q <= arr_n; tot_q <= tot_n; prev_q <= cur_q;
          if (pos_c < r_q && refrd_q != cur_q) mis_q <= mis_q + 1'b1;
          p_q <= p_next; k_q <= k_q + 5'd1;
        end
        ST_CMP: begin
          k_q <= 5'd1;
          if (!have_q || tot_q < best_s_q || (tot_q == best_s_q && mis_fin < best_m_q)) begin
            have_q <= 1'b1; best_s_q <= tot_q; best_m_q <= mis_fin;
          end else begin
            if (cut_q == n_q - 5'd1) begin
              cut_q <= '0; dir_q <= 1'b1;
              if (dir_q) k_q <= '0;
            end else cut_q <= cut_q + 5'd1;
          end
        end
        ST_COPY_RD: ;
        ST_COPY_WR: begin
          if (k_q == n_q) begin
            k_q <= '0;
            if (cut_q == n_q - 5'd1) begin
              cut_q <= '0; dir_q <= 1'b1;
            end else cut_q <= cut_q + 5'd1;
          end else k_q <= k_q + 5'd1;
        end
        ST_EMIT_RD: begin
          if (n_q == '0 && k_q == '0) begin
            best_s_q <= '0;
            best_m_q <= (r_q == 6'd0) ? 6'd1
                      : (6'(refrd_q != 5'd0) + (r_q - 6'd1));
          end
        end
        ST_EMIT_WAIT: ;
        ST_EMIT_PUSH: begin
          if (!res_full_i) k_q <= k_q + 5'd1;
        end
        default: ;
      endcase
    end
  end

  logic last_cand;
  assign last_cand = dir_q && (cut_q == n_q - 5'd1);

  always_comb begin
    state_d      = state_q;
    item_ready_o = 1'b0;
    res_push_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i && cmd_e'(item_i.command) == CMD_COMPUTE) begin
          state_d = ST_CAND;
        end
      end
      ST_CAND: state_d = (n_q == '0) ? ST_EMIT_RD : ST_RD;
      ST_RD:   state_d = ST_ACC;
      ST_ACC:  state_d = (k_q == n_q - 5'd1) ? ST_CMP : ST_RD;
      ST_CMP: begin
        if (!have_q || tot_q < best_s_q || (tot_q == best_s_q && mis_fin < best_m_q)) begin
          state_d = ST_COPY_RD;
        end else begin
          state_d = last_cand ? ST_EMIT_RD : ST_CAND;
        end
      end
      ST_COPY_RD: state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        if (k_q == n_q) state_d = last_cand ? ST_EMIT_RD : ST_CAND;
        else state_d = ST_COPY_RD;
      end
      ST_EMIT_RD:   state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: state_d = ST_EMIT_PUSH;
      ST_EMIT_PUSH: begin
        res_push_o = 1'b1;
        if (!res_full_i) begin
          state_d = ({1'b0, k_q} == len - 6'd1) ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  logic [63:0] sum_wide;
  always_comb begin
    sum_wide             = 64'(best_s_q);
    res_o.position       = k_q;
    res_o.route_node     = crd_q;
    res_o.arrival_sum    = (sum_wide > 64'h1FF_FFFF) ? '1 : sum_wide[SumW-1:0];
    res_o.mismatch_count = best_m_q;
    res_o.last           = ({1'b0, k_q} == len - 6'd1);
  end
endmodule
